// ===== rtl/lnpl_pkg.sv =====
// shared types and constants for the looped note pattern lookup
`timescale 1ns / 1ps

package lnpl_pkg;

    localparam int ACT_W   = 3;
    localparam int START_W = 24;
    localparam int DUR_W   = 24;
    localparam int PITCH_W = 7;
    localparam int VEL_W   = 7;
    localparam int VOICE_W = 4;
    localparam int TICK_W  = 32;
    localparam int LEN_W   = 25;
    localparam int FLAG_W  = 3;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CHECK  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FINISH = 3'd4;

    localparam int FLAG_PITCH    = 0;
    localparam int FLAG_TIMING   = 1;
    localparam int FLAG_DURATION = 2;

    localparam logic RES_QUERY = 1'b0;
    localparam logic RES_CHECK = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_QUERY,
        OP_CHECK,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [START_W-1:0] start;
        logic [DUR_W-1:0]   dur;
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   vel;
        logic [VOICE_W-1:0] voice;
        logic [TICK_W-1:0]  tick;
    } cmd_t;

    typedef struct packed {
        logic               kind;
        logic               found;
        logic [TICK_W-1:0]  start;
        logic [DUR_W-1:0]   dur;
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   vel;
        logic [VOICE_W-1:0] voice;
        logic               pass;
        logic               count_mm;
        logic               pitch_mm;
        logic               timing_mm;
        logic               dur_mm;
    } res_t;

endpackage

// ===== rtl/lnpl_front.sv =====
// front end: accepts input words, classifies the action and queues commands
`timescale 1ns / 1ps

module lnpl_front
    import lnpl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [ACT_W-1:0]   action,
    input  logic [START_W-1:0] note_start,
    input  logic [DUR_W-1:0]   note_duration,
    input  logic [PITCH_W-1:0] note_pitch,
    input  logic [VEL_W-1:0]   note_velocity,
    input  logic [VOICE_W-1:0] note_voice,
    input  logic [TICK_W-1:0]  query_tick,
    output logic               q_valid,
    output cmd_t               q_cmd,
    input  logic               q_pop
);

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    op_t               cls_op;
    logic              cls_ok;
    logic              push;
    logic              pop;
    cmd_t              new_cmd;

    always_comb
    begin
        cls_op = OP_CLEAR;
        cls_ok = 1'b1;
        unique case (action)
            ACT_CLEAR:  cls_op = OP_CLEAR;
            ACT_APPEND: cls_op = OP_APPEND;
            ACT_QUERY:  cls_op = OP_QUERY;
            ACT_CHECK:  cls_op = OP_CHECK;
            ACT_FINISH: cls_op = OP_FINISH;
            default:    cls_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        new_cmd.op    = cls_op;
        new_cmd.start = note_start;
        new_cmd.dur   = note_duration;
        new_cmd.pitch = note_pitch;
        new_cmd.vel   = note_velocity;
        new_cmd.voice = note_voice;
        new_cmd.tick  = query_tick;
    end

    assign in_stall = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    // unused actions are taken and dropped
    assign push     = in_valid && !in_stall && cls_ok;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_cmd    = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/lnpl_div.sv =====
// bit-serial remainder unit: tick modulo pattern length
`timescale 1ns / 1ps

module lnpl_div
    import lnpl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TICK_W-1:0] dividend,
    input  logic [LEN_W-1:0]  divisor,
    output logic              done,
    output logic [LEN_W-1:0]  rem
);

    localparam int CNT_W = $clog2(TICK_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TICK_W-1:0] quo_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  div_reg;
    logic [LEN_W:0]    trial;
    logic [LEN_W-1:0]  step_rem;

    always_comb
    begin
        trial = {rem_reg, quo_reg[TICK_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            step_rem = LEN_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            step_rem = trial[LEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TICK_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[TICK_W-2:0], 1'b0};
            rem_reg <= step_rem;
        end
    end

endmodule

// ===== rtl/lnpl_back.sv =====
// back end: note table, query scan, check bookkeeping and result register
`timescale 1ns / 1ps

module lnpl_back
    import lnpl_pkg::*;
#(
    parameter int MAX_NOTES = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic q_pop,
    output logic out_valid,
    input  logic out_stall,
    output res_t res
);

    localparam int IW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CW = $clog2(MAX_NOTES + 2);

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [DUR_W-1:0]   dur;
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   vel;
        logic [VOICE_W-1:0] voice;
    } note_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WALK,
        S_CHK
    } state_t;

    note_t mem [MAX_NOTES];
    note_t rd_data_reg;
    note_t wdata;
    logic  we;
    logic  rd_en;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] waddr;

    state_t            state_reg, state_next;
    logic [CW-1:0]     stored_reg, stored_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [CW-1:0]     checked_reg, checked_next;
    logic [FLAG_W-1:0] flags_reg, flags_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CW-1:0]     iss_reg, iss_next;
    logic              pend_reg, pend_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg, res_next;

    logic             div_start;
    logic             div_done;
    logic [LEN_W-1:0] div_rem;
    logic             slot_free;
    logic [LEN_W-1:0] append_end;
    logic [LEN_W-1:0] ent_end;
    logic             hit;
    logic             cnt_mm;

    lnpl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (q_cmd.tick),
        .divisor  (plen_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign slot_free  = !out_valid_reg || !out_stall;
    assign append_end = {1'b0, q_cmd.start} + {1'b0, q_cmd.dur};
    assign ent_end    = {1'b0, rd_data_reg.start} + {1'b0, rd_data_reg.dur};
    assign hit        = pend_reg && (pos_reg >= {1'b0, rd_data_reg.start})
                        && (pos_reg < ent_end);
    assign cnt_mm     = (checked_reg != stored_reg);
    assign waddr      = stored_reg[IW-1:0];

    always_comb
    begin
        wdata.start = q_cmd.start;
        wdata.dur   = q_cmd.dur;
        wdata.pitch = q_cmd.pitch;
        wdata.vel   = q_cmd.vel;
        wdata.voice = q_cmd.voice;
    end

    always_comb
    begin
        state_next     = state_reg;
        stored_next    = stored_reg;
        plen_next      = plen_reg;
        checked_next   = checked_reg;
        flags_next     = flags_reg;
        cmd_next       = cmd_reg;
        iss_next       = iss_reg;
        pend_next      = pend_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        we             = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    unique case (q_cmd.op)
                        OP_CLEAR:
                        begin
                            stored_next  = '0;
                            plen_next    = '0;
                            checked_next = '0;
                            flags_next   = '0;
                        end
                        OP_APPEND:
                        begin
                            if (stored_reg < CW'(MAX_NOTES))
                            begin
                                we          = 1'b1;
                                stored_next = stored_reg + 1'b1;
                                if (append_end > plen_reg)
                                begin
                                    plen_next = append_end;
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            if (plen_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                res_next       = '0;
                                res_next.kind  = RES_QUERY;
                                res_next.start = q_cmd.tick;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        OP_CHECK:
                        begin
                            if (checked_reg < stored_reg)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = checked_reg[IW-1:0];
                                state_next = S_CHK;
                            end
                            else if (checked_reg < CW'(MAX_NOTES + 1))
                            begin
                                checked_next = checked_reg + 1'b1;
                            end
                        end
                        OP_FINISH:
                        begin
                            out_valid_next    = 1'b1;
                            res_next          = '0;
                            res_next.kind     = RES_CHECK;
                            res_next.count_mm = cnt_mm;
                            if (!cnt_mm)
                            begin
                                res_next.pitch_mm  = flags_reg[FLAG_PITCH];
                                res_next.timing_mm = flags_reg[FLAG_TIMING];
                                res_next.dur_mm    = flags_reg[FLAG_DURATION];
                                res_next.pass      = (flags_reg == '0);
                            end
                            checked_next = '0;
                            flags_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pos_next   = div_rem;
                    iss_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (hit)
                begin
                    out_valid_next = 1'b1;
                    res_next       = '0;
                    res_next.kind  = RES_QUERY;
                    res_next.found = 1'b1;
                    res_next.start = TICK_W'(rd_data_reg.start);
                    res_next.dur   = rd_data_reg.dur;
                    res_next.pitch = rd_data_reg.pitch;
                    res_next.vel   = rd_data_reg.vel;
                    res_next.voice = rd_data_reg.voice;
                    state_next     = S_IDLE;
                end
                else if (!pend_reg && (iss_reg == stored_reg))
                begin
                    out_valid_next = 1'b1;
                    res_next       = '0;
                    res_next.kind  = RES_QUERY;
                    res_next.start = cmd_reg.tick;
                    state_next     = S_IDLE;
                end
                else if (iss_reg < stored_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = iss_reg[IW-1:0];
                    iss_next  = iss_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_CHK:
            begin
                if (rd_data_reg.pitch != cmd_reg.pitch)
                begin
                    flags_next[FLAG_PITCH] = 1'b1;
                end
                if (rd_data_reg.start != cmd_reg.start)
                begin
                    flags_next[FLAG_TIMING] = 1'b1;
                end
                if (rd_data_reg.dur != cmd_reg.dur)
                begin
                    flags_next[FLAG_DURATION] = 1'b1;
                end
                checked_next = checked_reg + 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stored_reg    <= '0;
            plen_reg      <= '0;
            checked_reg   <= '0;
            flags_reg     <= '0;
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stored_reg    <= stored_next;
            plen_reg      <= plen_next;
            checked_reg   <= checked_next;
            flags_reg     <= flags_next;
            iss_reg       <= iss_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        pos_reg <= pos_next;
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/looped_note_pattern_lookup.sv =====
// Looped note pattern lookup: a table of pattern notes answers tick queries
// and checks generated note sequences against the stored pattern.
// Input channel: in_valid / in_stall carry one word with an action and note
// or tick fields; a word is taken when in_valid is high and in_stall is low.
// Clear, append and check words give no result; query and finish words give
// one result word on the output channel (out_valid / out_stall).
// A two-entry command queue sits behind the input, so words are taken while
// the back end works or while a result waits on a stalled receiver.
// A query on an empty pattern is answered from the idle state, without the remainder unit.
// Otherwise a 32-step serial remainder unit reduces the tick, then the table
// is scanned one entry per cycle.
// A result word holds while out_stall is high; the next command waits.
// Reset empties the queue and the table and abandons any check in progress.
`timescale 1ns / 1ps

module looped_note_pattern_lookup
    import lnpl_pkg::*;
#(
    parameter int MAX_NOTES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [ACT_W-1:0]   action,
    input  logic [START_W-1:0] note_start,
    input  logic [DUR_W-1:0]   note_duration,
    input  logic [PITCH_W-1:0] note_pitch,
    input  logic [VEL_W-1:0]   note_velocity,
    input  logic [VOICE_W-1:0] note_voice,
    input  logic [TICK_W-1:0]  query_tick,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_kind,
    output logic               found,
    output logic [TICK_W-1:0]  out_start,
    output logic [DUR_W-1:0]   out_duration,
    output logic [PITCH_W-1:0] out_pitch,
    output logic [VEL_W-1:0]   out_velocity,
    output logic [VOICE_W-1:0] out_voice,
    output logic               check_pass,
    output logic               count_mismatch,
    output logic               pitch_diff,
    output logic               timing_diff,
    output logic               duration_diff
);

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;
    res_t res;

    lnpl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .note_start    (note_start),
        .note_duration (note_duration),
        .note_pitch    (note_pitch),
        .note_velocity (note_velocity),
        .note_voice    (note_voice),
        .query_tick    (query_tick),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    lnpl_back #(
        .MAX_NOTES (MAX_NOTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign result_kind    = res.kind;
    assign found          = res.found;
    assign out_start      = res.start;
    assign out_duration   = res.dur;
    assign out_pitch      = res.pitch;
    assign out_velocity   = res.vel;
    assign out_voice      = res.voice;
    assign check_pass     = res.pass;
    assign count_mismatch = res.count_mm;
    assign pitch_diff     = res.pitch_mm;
    assign timing_diff    = res.timing_mm;
    assign duration_diff  = res.dur_mm;

    a_verdict_no_note: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == RES_CHECK) |->
            (!found && out_duration == '0 && out_pitch == '0 && out_start == '0))
        else $error("check verdict carries note fields");

    a_answer_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == RES_QUERY) |->
            (!check_pass && !count_mismatch && !pitch_diff
             && !timing_diff && !duration_diff))
        else $error("query answer carries verdict fields");

    a_pass_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (check_pass || count_mismatch)) |->
            (!pitch_diff && !timing_diff && !duration_diff
             && !(check_pass && count_mismatch)))
        else $error("verdict flags inconsistent");

    a_rest_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == RES_QUERY && !found) |->
            (out_duration == '0 && out_pitch == '0 && out_velocity == '0
             && out_voice == '0))
        else $error("rest answer carries note fields");

endmodule
